@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro takes a label, clock, reset, a condition pair and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fdrl_pkg.sv @@
// Package for the recent-id list: default sizes, register constants and
// the command/status structs between controller and datapath. No dependencies.
package fdrl_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 32;
  localparam int CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic latch;        // take the request into the datapath
    logic rd_issue;     // read store at the scan pointer
    logic step;         // move scan to the next older entry
    logic emit_empty;   // dump of an empty list
    logic emit_dump;    // one dump entry
    logic emit_hit;     // access found id
    logic emit_insert;  // access stores id, maybe evicting oldest
  } fdrl_cmd_t;

  typedef struct packed {
    logic is_dump;
    logic fill_zero;
    logic at_last;      // scan is at the oldest entry
    logic match;        // read data equals request id
    logic out_free;     // output register can take a result
  } fdrl_status_t;

endpackage

@@ src/fdrl_ctrl.sv @@
// Controller for the recent-id list: sequences the scan of the store.
// Depends on fdrl_pkg for the command and status structs.
module fdrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fdrl_pkg::fdrl_status_t status,
  output fdrl_pkg::fdrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (status.fill_zero) begin
          if (status.out_free) begin
            cmd.emit_empty  = status.is_dump;
            cmd.emit_insert = !status.is_dump;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.is_dump) begin
          if (status.out_free) begin
            cmd.emit_dump = 1'b1;
            if (status.at_last) begin
              state_next = S_IDLE;
            end else begin
              cmd.step   = 1'b1;
              state_next = S_READ;
            end
          end
        end else if (status.match) begin
          if (status.out_free) begin
            cmd.emit_hit = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (status.at_last) begin
          if (status.out_free) begin
            cmd.emit_insert = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/fdrl_dpath.sv @@
// Datapath for the recent-id list: id store memory, list pointers, capacity
// register and output register. Depends on fdrl_pkg.
module fdrl_dpath #(
  parameter int DEPTH    = fdrl_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = fdrl_pkg::ID_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fdrl_pkg::CAP_W-1:0]       cfg_wdata,
  input  logic                             req_type,
  input  logic [ID_WIDTH-1:0]              item_id,
  input  fdrl_pkg::fdrl_cmd_t              cmd,
  output fdrl_pkg::fdrl_status_t           status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic                             evicted,
  output logic [ID_WIDTH-1:0]              entry_id,
  output logic                             entry_valid,
  output logic [$clog2(DEPTH+1)-1:0]       fill_count,
  output logic                             last
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int CMPW = (FW > fdrl_pkg::CAP_W) ? FW : fdrl_pkg::CAP_W;
  localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);

  logic [ID_WIDTH-1:0] mem [DEPTH];
  logic [ID_WIDTH-1:0] rd_data;

  logic [fdrl_pkg::CAP_W-1:0] cap;
  logic [FW-1:0]              fill;
  logic [PW-1:0]              newest;
  logic [PW-1:0]              ptr;
  logic [PW-1:0]              age;
  logic                       req_dump;
  logic [ID_WIDTH-1:0]        req_id;

  logic [FW-1:0] eff_cap;
  logic          room;
  logic [PW-1:0] newest_inc;
  logic [PW-1:0] wr_pos;
  logic          emit;

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (cap == '0) begin
      eff_cap = FW'(1);
    end else if (CMPW'(cap) > CMPW'(DEPTH)) begin
      eff_cap = FW'(DEPTH);
    end else begin
      eff_cap = FW'(cap);
    end
  end

  assign room       = (fill < eff_cap);
  assign newest_inc = (newest == LAST_POS) ? '0 : newest + PW'(1);
  assign wr_pos     = (fill == '0) ? newest : newest_inc;
  assign emit       = cmd.emit_empty | cmd.emit_dump | cmd.emit_hit | cmd.emit_insert;

  assign status.is_dump   = req_dump;
  assign status.fill_zero = (fill == '0);
  assign status.at_last   = ((FW'(age) + FW'(1)) == fill);
  assign status.match     = (rd_data == req_id);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.emit_insert) begin
      mem[wr_pos] <= req_id;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_dump <= req_type;
      req_id   <= item_id;
      age      <= '0;
      ptr      <= newest;
    end else if (cmd.step) begin
      age <= age + PW'(1);
      ptr <= (ptr == '0) ? LAST_POS : ptr - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= fdrl_pkg::CAP_RESET;
      fill   <= '0;
      newest <= '0;
    end else if (cfg_we) begin
      cap    <= cfg_wdata;
      fill   <= '0;
      newest <= '0;
    end else if (cmd.emit_insert) begin
      newest <= wr_pos;
      if (room) begin
        fill <= fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit         <= cmd.emit_hit;
      evicted     <= cmd.emit_insert && !room;
      entry_valid <= cmd.emit_dump;
      last        <= !cmd.emit_dump || status.at_last;
      if (cmd.emit_dump || (cmd.emit_insert && !room)) begin
        entry_id <= rd_data;
      end else begin
        entry_id <= '0;
      end
      if (cmd.emit_insert && room) begin
        fill_count <= fill + FW'(1);
      end else begin
        fill_count <= fill;
      end
    end
  end

endmodule

@@ src/fifo_dedup_recent_list.sv @@
// Channel   Signals                                    Moves on
// in        in_valid/in_ready, req_type, item_id       in_valid & in_ready
// out       out_valid/out_ready, hit, evicted,         out_valid & out_ready
//           entry_id, entry_valid, fill_count, last
// cfg       cfg_we, cfg_wdata (capacity)               cfg_we
//
// One request at a time. The store is a single-port memory scanned newest
// first; the idle state takes the request, then each entry read passes the
// read and check states. An access scans up to the fill level (fewer on a
// hit); a dump reads every entry; on an empty list either answers from the
// read state. Output stalls hold the scan at the pending result. Reset empties
// the list and sets capacity to 16; no clearing pass runs over the store.
// Top level: depends on fdrl_pkg, fdrl_ctrl and fdrl_dpath.
module fifo_dedup_recent_list #(
  parameter int DEPTH    = fdrl_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = fdrl_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fdrl_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [ID_WIDTH-1:0]         item_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic                        evicted,
  output logic [ID_WIDTH-1:0]         entry_id,
  output logic                        entry_valid,
  output logic [$clog2(DEPTH+1)-1:0]  fill_count,
  output logic                        last
);

  fdrl_pkg::fdrl_cmd_t    cmd;
  fdrl_pkg::fdrl_status_t status;

  fdrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fdrl_dpath #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_type    (req_type),
    .item_id     (item_id),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .evicted     (evicted),
    .entry_id    (entry_id),
    .entry_valid (entry_valid),
    .fill_count  (fill_count),
    .last        (last)
  );

endmodule

@@ src/fdrl_checker.sv @@
// Port-level checker for the recent-id list, bound to the top level.
// Depends on fdrl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdrl_checker #(
  parameter int DEPTH    = fdrl_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = fdrl_pkg::ID_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic                        evicted,
  input logic [ID_WIDTH-1:0]         entry_id,
  input logic                        entry_valid,
  input logic [$clog2(DEPTH+1)-1:0]  fill_count,
  input logic                        last
);

  localparam int FW = $clog2(DEPTH + 1);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(entry_id) && $stable(last), "stalled result changed")
  // a hit or eviction result is marked last
  `ASSERT_IMP(a_access_last, clk, rst, out_valid && (hit || evicted), last, "access result not last")
  `ASSERT_IMP(a_kind_excl, clk, rst, out_valid && entry_valid, !hit && !evicted, "dump entry marked as access")
  `ASSERT_IMP(a_hit_nonempty, clk, rst, out_valid && (hit || evicted || entry_valid), fill_count != '0, "hit or entry with empty list")
  `ASSERT_IMP(a_fill_bound, clk, rst, out_valid, (FW+1)'(fill_count) <= (FW+1)'(DEPTH), "fill count above depth")

endmodule

bind fifo_dedup_recent_list fdrl_checker #(
  .DEPTH    (DEPTH),
  .ID_WIDTH (ID_WIDTH)
) u_fdrl_checker (.*);
